### hdl/bvot_pkg.sv
`timescale 1ns / 1ps

package bvot_pkg;

   localparam int COORD_BITS = 16;
   localparam int LANES      = 3;
   localparam int WORD_BITS  = LANES * COORD_BITS;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SUM_BITS   = COORD_BITS + 2;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int BSQ_BITS   = 2 * COORD_BITS + 1;
   localparam int DSUM_BITS  = 2 * COORD_BITS + 2;

   typedef enum logic [1:0] {
      REQ_INTERSECT = 2'd0,
      REQ_POINT     = 2'd1,
      REQ_CONTAIN   = 2'd2,
      REQ_UNUSED    = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      TEST_NONE,
      TEST_BOX_BOX,
      TEST_ROOT_BELOW,
      TEST_NEAR,
      TEST_PT_SPH,
      TEST_TWO_PT_SPH,
      TEST_PT_BOX,
      TEST_TWO_PT_BOX,
      TEST_SPH_IN_BOX
   } test_type;

   typedef struct packed {
      test_type                         test;
      logic [LANES-1:0][SUM_BITS-1:0]   ctr;
      logic [LANES-1:0][SUM_BITS-1:0]   ext;
      logic [LANES-1:0][DIFF_BITS-1:0]  e_hi;
      logic [LANES-1:0][DIFF_BITS-1:0]  e_lo;
      logic [COORD_BITS-1:0]            rb;
      logic                             pt0;
      logic                             pt1;
      logic [LANES-1:0][DIFF_BITS-1:0]  d0;
      logic [LANES-1:0][DIFF_BITS-1:0]  d1;
      logic [DIFF_BITS-1:0]             bound;
   } s1_type;

   typedef struct packed {
      test_type                       test;
      logic                           box_ok;
      logic [LANES-1:0][SQ_BITS-1:0]  sq0;
      logic [LANES-1:0][SQ_BITS-1:0]  sq1;
      logic [BSQ_BITS-1:0]            bsq;
      logic                           bound_pos;
   } s2_type;

   function automatic logic [DIFF_BITS-1:0] sx_d(input logic [COORD_BITS-1:0] v);
      return {v[COORD_BITS-1], v};
   endfunction

   function automatic logic [SUM_BITS-1:0] sx_s(input logic [COORD_BITS-1:0] v);
      return {{2{v[COORD_BITS-1]}}, v};
   endfunction

endpackage

### hdl/bvot_front.sv
`timescale 1ns / 1ps

module bvot_front import bvot_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [1:0]           req_type,
   input  logic                 a_is_sphere,
   input  logic [WORD_BITS-1:0] a_lo,
   input  logic [WORD_BITS-1:0] a_hi,
   input  logic                 b_is_sphere,
   input  logic [WORD_BITS-1:0] b_lo,
   input  logic [WORD_BITS-1:0] b_hi,
   output logic                 s1_valid,
   output s1_type               s1
);

   logic signed [COORD_BITS-1:0] alo [LANES];
   logic signed [COORD_BITS-1:0] ahi [LANES];
   logic signed [COORD_BITS-1:0] blo [LANES];
   logic signed [COORD_BITS-1:0] bhi [LANES];
   logic signed [COORD_BITS-1:0] c_ax [LANES];
   logic signed [COORD_BITS-1:0] mn_ax [LANES];
   logic signed [COORD_BITS-1:0] mx_ax [LANES];
   logic signed [COORD_BITS-1:0] q_ax [LANES];
   logic [DIFF_BITS-1:0]         dsb [LANES];
   logic signed [COORD_BITS-1:0] ra;
   logic signed [COORD_BITS-1:0] rb;
   logic                         sph_box;
   req_code_type                 code;

   s1_type s1_in;
   s1_type s1_ff;
   logic   s1_valid_in;
   logic   s1_valid_ff;

   // lane unpack and sphere to box clamp
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         alo[i]   = a_lo[i*COORD_BITS +: COORD_BITS];
         ahi[i]   = a_hi[i*COORD_BITS +: COORD_BITS];
         blo[i]   = b_lo[i*COORD_BITS +: COORD_BITS];
         bhi[i]   = b_hi[i*COORD_BITS +: COORD_BITS];
         c_ax[i]  = a_is_sphere ? alo[i] : blo[i];
         mn_ax[i] = a_is_sphere ? blo[i] : alo[i];
         mx_ax[i] = a_is_sphere ? bhi[i] : ahi[i];
         q_ax[i]  = (c_ax[i] < mx_ax[i]) ? c_ax[i] : mx_ax[i];
         if (q_ax[i] < mn_ax[i]) begin
            q_ax[i] = mn_ax[i];
         end
         dsb[i] = sx_d(q_ax[i]) - sx_d(c_ax[i]);
      end
      ra = ahi[0];
      rb = bhi[0];
   end

   assign code    = req_code_type'(req_type);
   assign sph_box = (code == REQ_INTERSECT) && (a_is_sphere != b_is_sphere);

   always_comb begin
      s1_in     = '0;
      s1_in.rb  = rb;
      s1_in.pt0 = 1'b1;
      s1_in.pt1 = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         s1_in.ctr[i]  = (sx_s(alo[i]) + sx_s(ahi[i])) - (sx_s(blo[i]) + sx_s(bhi[i]));
         s1_in.ext[i]  = (sx_s(ahi[i]) - sx_s(alo[i])) + (sx_s(bhi[i]) - sx_s(blo[i]));
         s1_in.e_hi[i] = sx_d(ahi[i]) - sx_d(blo[i]);
         s1_in.e_lo[i] = sx_d(blo[i]) - sx_d(alo[i]);
         s1_in.d0[i]   = sph_box ? dsb[i] : (sx_d(alo[i]) - sx_d(blo[i]));
         s1_in.d1[i]   = sx_d(alo[i]) - sx_d(bhi[i]);
         if (blo[i] < alo[i] || blo[i] > ahi[i]) begin
            s1_in.pt0 = 1'b0;
         end
         if (bhi[i] < alo[i] || bhi[i] > ahi[i]) begin
            s1_in.pt1 = 1'b0;
         end
      end
      unique case (code)
         REQ_INTERSECT: begin
            if (!a_is_sphere && !b_is_sphere) begin
               s1_in.test = TEST_BOX_BOX;
            end else if (a_is_sphere && b_is_sphere) begin
               s1_in.test  = TEST_ROOT_BELOW;
               s1_in.bound = sx_d(ra) + sx_d(rb);
            end else begin
               s1_in.test  = TEST_NEAR;
               s1_in.bound = a_is_sphere ? sx_d(ra) : sx_d(rb);
            end
         end
         REQ_POINT: begin
            s1_in.test  = a_is_sphere ? TEST_PT_SPH : TEST_PT_BOX;
            s1_in.bound = sx_d(ra);
         end
         REQ_CONTAIN: begin
            if (!b_is_sphere) begin
               s1_in.test  = a_is_sphere ? TEST_TWO_PT_SPH : TEST_TWO_PT_BOX;
               s1_in.bound = sx_d(ra);
            end else if (a_is_sphere) begin
               s1_in.test  = TEST_ROOT_BELOW;
               s1_in.bound = sx_d(ra) - sx_d(rb);
            end else begin
               s1_in.test = TEST_SPH_IN_BOX;
            end
         end
         REQ_UNUSED: begin
            s1_in.test = TEST_NONE;
         end
      endcase
   end

   assign s1_valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule

### hdl/bvot_square.sv
`timescale 1ns / 1ps

module bvot_square import bvot_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   s1_valid,
   input  s1_type s1,
   output logic   s2_valid,
   output s2_type s2
);

   logic signed [2*DIFF_BITS-1:0] p0 [LANES];
   logic signed [2*DIFF_BITS-1:0] p1 [LANES];
   logic signed [2*DIFF_BITS-1:0] pb;
   logic signed [SUM_BITS:0]      c_w [LANES];
   logic signed [SUM_BITS:0]      cn_w [LANES];
   logic signed [SUM_BITS:0]      x_w [LANES];
   logic signed [DIFF_BITS:0]     eh_w [LANES];
   logic signed [DIFF_BITS:0]     el_w [LANES];
   logic signed [DIFF_BITS:0]     r_w;
   logic                          bb_ok;
   logic                          side_ok;

   s2_type s2_in;
   s2_type s2_ff;
   logic   s2_valid_in;
   logic   s2_valid_ff;

   // squares of the distance terms
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         p0[i] = $signed(s1.d0[i]) * $signed(s1.d0[i]);
         p1[i] = $signed(s1.d1[i]) * $signed(s1.d1[i]);
      end
      pb = $signed(s1.bound) * $signed(s1.bound);
   end

   // box only comparisons
   always_comb begin
      bb_ok   = 1'b1;
      side_ok = 1'b1;
      r_w     = $signed({{2{s1.rb[COORD_BITS-1]}}, s1.rb});
      for (int i = 0; i < LANES; i++) begin
         c_w[i]  = $signed({s1.ctr[i][SUM_BITS-1], s1.ctr[i]});
         cn_w[i] = -c_w[i];
         x_w[i]  = $signed({s1.ext[i][SUM_BITS-1], s1.ext[i]});
         eh_w[i] = $signed({s1.e_hi[i][DIFF_BITS-1], s1.e_hi[i]});
         el_w[i] = $signed({s1.e_lo[i][DIFF_BITS-1], s1.e_lo[i]});
         if (!(c_w[i] <= x_w[i] && cn_w[i] <= x_w[i])) begin
            bb_ok = 1'b0;
         end
         if ((eh_w[i] < r_w && -eh_w[i] < r_w) || (el_w[i] < r_w && -el_w[i] < r_w)) begin
            side_ok = 1'b0;
         end
      end
   end

   always_comb begin
      s2_in.test      = s1.test;
      s2_in.bsq       = pb[BSQ_BITS-1:0];
      s2_in.bound_pos = $signed(s1.bound) > 0;
      for (int i = 0; i < LANES; i++) begin
         s2_in.sq0[i] = p0[i][SQ_BITS-1:0];
         s2_in.sq1[i] = p1[i][SQ_BITS-1:0];
      end
      unique case (s1.test)
         TEST_BOX_BOX:    s2_in.box_ok = bb_ok;
         TEST_PT_BOX:     s2_in.box_ok = s1.pt0;
         TEST_TWO_PT_BOX: s2_in.box_ok = s1.pt0 && s1.pt1;
         TEST_SPH_IN_BOX: s2_in.box_ok = s1.pt0 && side_ok;
         default:         s2_in.box_ok = 1'b0;
      endcase
   end

   assign s2_valid_in = s1_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
   end

   assign s2_valid = s2_valid_ff;
   assign s2       = s2_ff;

endmodule

### hdl/bvot_resolve.sv
`timescale 1ns / 1ps

module bvot_resolve import bvot_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   s2_valid,
   input  s2_type s2,
   output logic   rsp_strobe,
   output logic   rsp_hit
);

   logic [DSUM_BITS-1:0] s0;
   logic [DSUM_BITS-1:0] s1;
   logic [DSUM_BITS-1:0] b2;
   logic                 lt0;
   logic                 le0;
   logic                 le1;

   logic rsp_strobe_in;
   logic rsp_strobe_ff;
   logic rsp_hit_in;
   logic rsp_hit_ff;

   assign s0  = DSUM_BITS'(s2.sq0[0]) + DSUM_BITS'(s2.sq0[1]) + DSUM_BITS'(s2.sq0[2]);
   assign s1  = DSUM_BITS'(s2.sq1[0]) + DSUM_BITS'(s2.sq1[1]) + DSUM_BITS'(s2.sq1[2]);
   assign b2  = DSUM_BITS'(s2.bsq);
   assign lt0 = s0 < b2;
   assign le0 = s0 <= b2;
   assign le1 = s1 <= b2;

   always_comb begin
      unique case (s2.test)
         TEST_ROOT_BELOW: rsp_hit_in = lt0 && s2.bound_pos;
         TEST_NEAR:       rsp_hit_in = lt0;
         TEST_PT_SPH:     rsp_hit_in = le0;
         TEST_TWO_PT_SPH: rsp_hit_in = le0 && le1;
         TEST_BOX_BOX,
         TEST_PT_BOX,
         TEST_TWO_PT_BOX,
         TEST_SPH_IN_BOX: rsp_hit_in = s2.box_ok;
         default:         rsp_hit_in = 1'b0;
      endcase
   end

   assign rsp_strobe_in = s2_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_hit    = rsp_hit_ff;

endmodule

### hdl/bounding_volume_overlap_test_unit.sv
`timescale 1ns / 1ps

// bounding volume overlap test unit
// request channel: drive start high with req_type and the two regions
// (req_a_*, req_b_*); the word is taken at the rising edge where start is
// high and busy is low. busy stays low, so a new word can go in every cycle.
// coordinates are signed packed x,y,z lanes of COORD_BITS bits; a radius is
// the low lane of its hi word.
// response channel: rsp_strobe is high for exactly one cycle with rsp_hit
// valid in that cycle. words come out in the order they went in.
// throughput is one word per cycle, set by the three register stages
// (operand prep and clamp, squaring multipliers, sum and compare).
// reset clears the stage valid bits, so no strobe follows a reset until a
// new word is taken. the receiver cannot hold responses off and none is
// needed: the pipe never stalls.
module bounding_volume_overlap_test_unit import bvot_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic                 req_a_is_sphere,
   input  logic [WORD_BITS-1:0] req_a_lo,
   input  logic [WORD_BITS-1:0] req_a_hi,
   input  logic                 req_b_is_sphere,
   input  logic [WORD_BITS-1:0] req_b_lo,
   input  logic [WORD_BITS-1:0] req_b_hi,
   output logic                 rsp_strobe,
   output logic                 rsp_hit
);

   logic   in_valid;
   logic   s1_valid;
   s1_type s1;
   logic   s2_valid;
   s2_type s2;

   assign busy     = 1'b0;
   assign in_valid = start && !busy;

   bvot_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid),
      .req_type    (req_type),
      .a_is_sphere (req_a_is_sphere),
      .a_lo        (req_a_lo),
      .a_hi        (req_a_hi),
      .b_is_sphere (req_b_is_sphere),
      .b_lo        (req_b_lo),
      .b_hi        (req_b_hi),
      .s1_valid    (s1_valid),
      .s1          (s1)
   );

   bvot_square u_square (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1       (s1),
      .s2_valid (s2_valid),
      .s2       (s2)
   );

   bvot_resolve u_resolve (
      .clock      (clock),
      .reset      (reset),
      .s2_valid   (s2_valid),
      .s2         (s2),
      .rsp_strobe (rsp_strobe),
      .rsp_hit    (rsp_hit)
   );

   // every word taken gives a response
   a_latency : assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##3 rsp_strobe)
      else $error("missing response after accepted word");

   // no response without a matching word taken before it
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(in_valid, 3))
      else $error("response without a matching word");

   // unused request code answers with a miss
   a_unused_miss : assert property (@(posedge clock) disable iff (reset)
      (in_valid && req_type == REQ_UNUSED) |-> ##3 (rsp_strobe && !rsp_hit))
      else $error("unused request code gave a hit");

   // concentric spheres with non-negative radii, not both zero, intersect
   a_concentric : assert property (@(posedge clock) disable iff (reset)
      (in_valid && req_type == REQ_INTERSECT && req_a_is_sphere && req_b_is_sphere
       && req_a_lo == req_b_lo && !req_a_hi[COORD_BITS-1] && !req_b_hi[COORD_BITS-1]
       && (req_a_hi[COORD_BITS-1:0] != '0 || req_b_hi[COORD_BITS-1:0] != '0))
      |-> ##3 rsp_hit)
      else $error("concentric spheres reported apart");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import bvot_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 1250;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_type;
   logic req_a_is_sphere;
   logic [WORD_BITS-1:0] req_a_lo;
   logic [WORD_BITS-1:0] req_a_hi;
   logic req_b_is_sphere;
   logic [WORD_BITS-1:0] req_b_lo;
   logic [WORD_BITS-1:0] req_b_hi;
   logic rsp_strobe;
   logic rsp_hit;

   bit hit_due[$];
   int faults = 0;
   int cycle_count = 0;
   bit idle_on = 1'b1;

   bounding_volume_overlap_test_unit DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_a_is_sphere(req_a_is_sphere),
      .req_a_lo(req_a_lo),
      .req_a_hi(req_a_hi),
      .req_b_is_sphere(req_b_is_sphere),
      .req_b_lo(req_b_lo),
      .req_b_hi(req_b_hi),
      .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint coord(input logic [WORD_BITS-1:0] w, input int i);
      logic signed [COORD_BITS-1:0] v;
      v = w[i*COORD_BITS +: COORD_BITS];
      return longint'(v);
   endfunction

   function automatic logic [WORD_BITS-1:0] xyz(input int x, input int y, input int z);
      logic [COORD_BITS-1:0] lx, ly, lz;
      lx = COORD_BITS'(x);
      ly = COORD_BITS'(y);
      lz = COORD_BITS'(z);
      return {lz, ly, lx};
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint sq_dist(input logic [WORD_BITS-1:0] p, input logic [WORD_BITS-1:0] q);
      longint s, d;
      int i;
      s = 0;
      for (i = 0; i < LANES; i++) begin
         d = coord(p, i) - coord(q, i);
         s += d * d;
      end
      return s;
   endfunction

   function automatic bit root_below(input longint d2, input longint bound);
      if (bound <= 0)
         return 1'b0;
      return d2 < bound * bound;
   endfunction

   function automatic bit box_holds(input logic [WORD_BITS-1:0] mn, input logic [WORD_BITS-1:0] mx,
                                    input logic [WORD_BITS-1:0] p);
      int i;
      for (i = 0; i < LANES; i++)
         if (coord(p, i) < coord(mn, i) || coord(p, i) > coord(mx, i))
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit region_holds(input bit sph, input logic [WORD_BITS-1:0] lo,
                                       input logic [WORD_BITS-1:0] hi,
                                       input logic [WORD_BITS-1:0] p);
      longint r;
      r = coord(hi, 0);
      if (sph)
         return sq_dist(lo, p) <= r * r;
      return box_holds(lo, hi, p);
   endfunction

   function automatic bit sphere_meets_box(input logic [WORD_BITS-1:0] c, input longint r,
                                           input logic [WORD_BITS-1:0] mn,
                                           input logic [WORD_BITS-1:0] mx);
      longint s, q, d;
      int i;
      s = 0;
      for (i = 0; i < LANES; i++) begin
         q = (coord(c, i) < coord(mx, i)) ? coord(c, i) : coord(mx, i);
         if (q < coord(mn, i))
            q = coord(mn, i);
         d = q - coord(c, i);
         s += d * d;
      end
      return s < r * r;
   endfunction

   function automatic bit overlap_hit(input req_code_type kind, input bit a_sph,
                                      input logic [WORD_BITS-1:0] a_lo,
                                      input logic [WORD_BITS-1:0] a_hi,
                                      input bit b_sph,
                                      input logic [WORD_BITS-1:0] b_lo,
                                      input logic [WORD_BITS-1:0] b_hi);
      longint ra, rb, gap_d, ext;
      bit ok;
      int i;
      ra = coord(a_hi, 0);
      rb = coord(b_hi, 0);
      ok = 1'b0;
      case (kind)
         REQ_INTERSECT: begin
            if (!a_sph && !b_sph) begin
               ok = 1'b1;
               for (i = 0; i < LANES; i++) begin
                  gap_d = magnitude((coord(a_lo, i) + coord(a_hi, i))
                                    - (coord(b_lo, i) + coord(b_hi, i)));
                  ext = (coord(a_hi, i) - coord(a_lo, i)) + (coord(b_hi, i) - coord(b_lo, i));
                  if (gap_d > ext)
                     ok = 1'b0;
               end
            end else if (a_sph && b_sph) begin
               ok = root_below(sq_dist(a_lo, b_lo), ra + rb);
            end else if (a_sph) begin
               ok = sphere_meets_box(a_lo, ra, b_lo, b_hi);
            end else begin
               ok = sphere_meets_box(b_lo, rb, a_lo, a_hi);
            end
         end
         REQ_POINT: begin
            ok = region_holds(a_sph, a_lo, a_hi, b_lo);
         end
         REQ_CONTAIN: begin
            if (!b_sph) begin
               ok = region_holds(a_sph, a_lo, a_hi, b_lo) && region_holds(a_sph, a_lo, a_hi, b_hi);
            end else if (a_sph) begin
               ok = root_below(sq_dist(a_lo, b_lo), ra - rb);
            end else if (box_holds(a_lo, a_hi, b_lo)) begin
               ok = 1'b1;
               for (i = 0; i < LANES; i++)
                  if (magnitude(coord(a_hi, i) - coord(b_lo, i)) < rb
                      || magnitude(coord(b_lo, i) - coord(a_lo, i)) < rb)
                     ok = 1'b0;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      return ok;
   endfunction

   function automatic logic [WORD_BITS-1:0] raw_word();
      logic [63:0] t;
      t = {$urandom, $urandom};
      return t[WORD_BITS-1:0];
   endfunction

   function automatic logic [WORD_BITS-1:0] shift(input logic [WORD_BITS-1:0] w, input int lo,
                                                  input int hi);
      int v[3];
      int i;
      for (i = 0; i < LANES; i++)
         v[i] = int'(coord(w, i)) + lo + int'($urandom_range(0, hi - lo));
      return xyz(v[0], v[1], v[2]);
   endfunction

   function automatic logic [WORD_BITS-1:0] radius_word(input int r);
      logic [WORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] lr;
      w = raw_word();
      lr = ($urandom_range(0, 7) == 0) ? COORD_BITS'(-r) : COORD_BITS'(r);
      w[COORD_BITS-1:0] = lr;
      return w;
   endfunction

   task automatic send_word(input req_code_type kind, input bit a_sph,
                            input logic [WORD_BITS-1:0] a_lo, input logic [WORD_BITS-1:0] a_hi,
                            input bit b_sph,
                            input logic [WORD_BITS-1:0] b_lo, input logic [WORD_BITS-1:0] b_hi);
      int gap;
      start <= 1'b1;
      req_type <= kind;
      req_a_is_sphere <= a_sph;
      req_a_lo <= a_lo;
      req_a_hi <= a_hi;
      req_b_is_sphere <= b_sph;
      req_b_lo <= b_lo;
      req_b_hi <= b_hi;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      hit_due.push_back(overlap_hit(kind, a_sph, a_lo, a_hi, b_sph, b_lo, b_hi));
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do
         @(posedge clock);
      while (hit_due.size() != 0);
   endtask

   task automatic test_box_pairs();
      send_word(REQ_INTERSECT, 1'b0, xyz(0, 0, 0), xyz(16, 16, 16),
                1'b0, xyz(16, 16, 16), xyz(32, 32, 32));
      send_word(REQ_INTERSECT, 1'b0, xyz(0, 0, 0), xyz(16, 16, 16),
                1'b0, xyz(17, 0, 0), xyz(32, 16, 16));
      send_word(REQ_INTERSECT, 1'b0, xyz(-32768, -32768, -32768), xyz(32767, 32767, 32767),
                1'b0, xyz(32767, -32768, 0), xyz(-32768, 32767, 0));
      send_word(REQ_INTERSECT, 1'b0, xyz(16, 16, 16), xyz(0, 0, 0),
                1'b0, xyz(4, 4, 4), xyz(8, 8, 8));
      send_word(REQ_INTERSECT, 1'b0, '1, '1, 1'b0, '0, '0);
   endtask

   task automatic test_sphere_pairs();
      send_word(REQ_INTERSECT, 1'b1, xyz(0, 0, 0), xyz(48, 0, 0),
                1'b1, xyz(80, 0, 0), xyz(32, 0, 0));
      send_word(REQ_INTERSECT, 1'b1, xyz(0, 0, 0), xyz(48, -1, -1),
                1'b1, xyz(79, 0, 0), xyz(32, 7, 7));
      send_word(REQ_INTERSECT, 1'b1, xyz(0, 0, 0), xyz(-16, 0, 0),
                1'b1, xyz(0, 0, 0), xyz(16, 0, 0));
      send_word(REQ_INTERSECT, 1'b1, xyz(-32768, 32767, 0), xyz(-32768, 0, 0), 1'b0,
                xyz(0, 0, 0), xyz(16, 16, 16));
      send_word(REQ_INTERSECT, 1'b0, xyz(0, 0, 0), xyz(16, 16, 16),
                1'b1, xyz(20, 20, 16), xyz(6, 0, 0));
      send_word(REQ_INTERSECT, 1'b0, xyz(16, 16, 16), xyz(0, 0, 0),
                1'b1, xyz(17, 16, 16), xyz(2, 0, 0));
   endtask

   task automatic test_points();
      send_word(REQ_POINT, 1'b0, xyz(-16, -16, -16), xyz(16, 16, 16),
                1'b0, xyz(16, -16, 0), '0);
      send_word(REQ_POINT, 1'b0, xyz(-16, -16, -16), xyz(16, 16, 16),
                1'b1, xyz(0, 0, 17), '1);
      send_word(REQ_POINT, 1'b1, xyz(0, 0, 0), xyz(5, 0, 0), 1'b1, xyz(3, 4, 0), xyz(-1, 9, 9));
      send_word(REQ_POINT, 1'b1, xyz(0, 0, 0), xyz(-5, 0, 0), 1'b0, xyz(3, 4, 1), '0);
      send_word(REQ_POINT, 1'b1, xyz(32767, 32767, 32767), xyz(32767, 0, 0), 1'b0,
                xyz(-32768, -32768, -32768), '1);
   endtask

   task automatic test_containment();
      send_word(REQ_CONTAIN, 1'b0, xyz(0, 0, 0), xyz(64, 64, 64),
                1'b0, xyz(0, 8, 8), xyz(64, 16, 16));
      send_word(REQ_CONTAIN, 1'b1, xyz(0, 0, 0), xyz(64, 0, 0),
                1'b0, xyz(-8, -8, -8), xyz(8, 8, 8));
      send_word(REQ_CONTAIN, 1'b1, xyz(0, 0, 0), xyz(64, 0, 0),
                1'b1, xyz(32, 0, 0), xyz(31, 0, 0));
      send_word(REQ_CONTAIN, 1'b1, xyz(0, 0, 0), xyz(64, 0, 0),
                1'b1, xyz(32, 0, 0), xyz(32, 0, 0));
      send_word(REQ_CONTAIN, 1'b0, xyz(0, 0, 0), xyz(64, 64, 64),
                1'b1, xyz(16, 32, 32), xyz(16, 0, 0));
      send_word(REQ_CONTAIN, 1'b0, xyz(0, 0, 0), xyz(64, 64, 64),
                1'b1, xyz(70, 32, 32), xyz(-8, 0, 0));
   endtask

   task automatic test_unused_type();
      send_word(REQ_UNUSED, 1'b0, xyz(0, 0, 0), xyz(16, 16, 16),
                1'b0, xyz(0, 0, 0), xyz(16, 16, 16));
      send_word(REQ_UNUSED, 1'b1, raw_word(), raw_word(), 1'b1, raw_word(), raw_word());
   endtask

   task automatic test_random_pairs(input int count);
      int n, span, ea, eb, mode;
      req_code_type kind;
      bit a_sph, b_sph;
      logic [WORD_BITS-1:0] c, bc, a_lo, a_hi, b_lo, b_hi;
      for (n = 0; n < count; n++) begin
         if (n % 100 == 0)
            idle_on = ($urandom_range(0, 2) != 0);
         if (n == count / 2)
            drain();
         kind = ($urandom_range(0, 15) == 0) ? REQ_UNUSED : req_code_type'($urandom_range(0, 2));
         a_sph = 1'($urandom_range(0, 1));
         b_sph = 1'($urandom_range(0, 1));
         mode = $urandom_range(0, 19);
         if (mode < 3) begin
            a_lo = raw_word();
            a_hi = raw_word();
            b_lo = raw_word();
            b_hi = raw_word();
         end else begin
            span = 1 << $urandom_range(1, (mode < 17) ? 9 : 14);
            c = shift('0, -span, span);
            ea = $urandom_range(0, span);
            eb = $urandom_range(0, ea);
            a_lo = a_sph ? c : shift(c, -ea, 0);
            a_hi = a_sph ? radius_word(ea) : shift(c, 0, ea);
            bc = shift(c, -ea, ea);
            b_lo = b_sph ? bc : shift(bc, -eb, 0);
            b_hi = b_sph ? radius_word(eb) : shift(bc, 0, eb);
         end
         send_word(kind, a_sph, a_lo, a_hi, b_sph, b_lo, b_hi);
      end
   endtask

   always @(posedge clock) begin
      bit due;
      if (!reset && rsp_strobe === 1'b1) begin
         if (hit_due.size() == 0) begin
            faults++;
            $display("%0t: unexpected result word, expected none, got hit %b", $time, rsp_hit);
         end else begin
            due = hit_due.pop_front();
            if (rsp_hit !== due) begin
               faults++;
               $display("%0t: hit mismatch, expected %b, got %b", $time, due, rsp_hit);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_type <= REQ_INTERSECT;
      req_a_is_sphere <= 1'b0;
      req_a_lo <= '0;
      req_a_hi <= '0;
      req_b_is_sphere <= 1'b0;
      req_b_lo <= '0;
      req_b_hi <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_box_pairs();
      test_sphere_pairs();
      test_points();
      test_containment();
      test_unused_type();
      drain();
      test_random_pairs(RANDOM_WORDS);
      drain();
      repeat (8) @(posedge clock);
      if (faults == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
